@@ rtl/core/msct_pkg.sv @@
// ----------------------------------------------------------------------------
// msct_pkg
// Shared types, codes and sizes for the countdown timer slot table.
// ----------------------------------------------------------------------------
package msct_pkg;

	localparam int SLOTS       = 16;
	localparam int COUNT_BITS  = 16;
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int REP_W  = $clog2(MAX_RESULTS + 1);

	typedef logic [COUNT_BITS-1:0] cnt_t;

	localparam cnt_t COUNT_MAX = '1;

	typedef enum logic [1:0] {
		K_TICK    = 2'd0,
		K_ADD     = 2'd1,
		K_CANCEL  = 2'd2,
		K_RELEASE = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		RS_RUNNING   = 2'd1,
		RS_CANCELLED = 2'd2,
		RS_FINISHED  = 2'd3
	} rs_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_NOSPACE   = 3'd2,
		ST_CANCELLED = 3'd3,
		ST_FINISHED  = 3'd4,
		ST_BUSY      = 3'd5
	} stat_e;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_TICK   = 3'd1,
		ACT_CLAIM  = 3'd2,
		ACT_CANCEL = 3'd3,
		ACT_FREE   = 3'd4
	} act_e;

	// broadcast to every cell; act applies only at the token cell
	typedef struct packed {
		logic start;
		logic shift;
		logic clear;
		act_e act;
		cnt_t period;
		logic repeats;
	} ctl_t;

	// state of the token-holding cell, all zero from the others
	typedef struct packed {
		logic in_use;
		logic [1:0] run_state;
		cnt_t ticks;
		logic repeats;
	} resp_t;

	function automatic cnt_t sat_period(input logic [15:0] p);
		logic [47:0] w;
		w = 48'(p);
		if (w > 48'(COUNT_MAX)) begin
			return COUNT_MAX;
		end
		return COUNT_BITS'(w);
	endfunction

endpackage

@@ rtl/core/msct_cell.sv @@
// ----------------------------------------------------------------------------
// msct_cell
// One timer slot: holds its state and passes the scan token to the next slot.
// ----------------------------------------------------------------------------
module msct_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_i,
	input  msct_pkg::ctl_t ctl,
	output logic           tok_o,
	output msct_pkg::resp_t resp
);
	import msct_pkg::*;

	logic tok_q;
	logic in_use_q;
	rs_e  rs_q;
	cnt_t reload_q;
	cnt_t ticks_q;
	logic rep_q;

	assign tok_o = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q    <= 1'b0;
			in_use_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				tok_q <= 1'b0;
			end else if (ctl.shift) begin
				tok_q <= tok_i;
			end
			if (tok_q && ctl.act == ACT_CLAIM) begin
				in_use_q <= 1'b1;
			end else if (tok_q && ctl.act == ACT_FREE) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_q) begin
			unique case (ctl.act)
				ACT_CLAIM: begin
					rs_q     <= RS_RUNNING;
					reload_q <= ctl.period;
					ticks_q  <= ctl.period;
					rep_q    <= ctl.repeats;
				end
				ACT_TICK: begin
					if (ticks_q == COUNT_BITS'(1)) begin
						if (rep_q) begin
							ticks_q <= reload_q;
						end else begin
							rs_q <= RS_FINISHED;
						end
					end else begin
						ticks_q <= ticks_q - COUNT_BITS'(1);
					end
				end
				ACT_CANCEL: begin
					rs_q <= RS_CANCELLED;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		resp = '0;
		if (tok_q) begin
			resp.in_use    = in_use_q;
			resp.run_state = rs_q;
			resp.ticks     = ticks_q;
			resp.repeats   = rep_q;
		end
	end

endmodule

@@ rtl/core/msct_ctrl.sv @@
// ----------------------------------------------------------------------------
// msct_ctrl
// Command sequencer: walks the token along the slots and forms result words.
// ----------------------------------------------------------------------------
module msct_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      kind,
	input  logic [15:0]     period_ticks,
	input  logic            periodic,
	input  logic [5:0]      slot_id,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      status,
	output logic [5:0]      slot,
	output logic            fired,
	output logic            last,
	input  msct_pkg::resp_t resp [msct_pkg::SLOTS],
	output msct_pkg::ctl_t  ctl
);
	import msct_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE  = 3'b001,
		F_SCAN  = 3'b010,
		F_FLUSH = 3'b100
	} fsm_e;

	fsm_e              fsm_q, fsm_d;
	logic [SLOT_W-1:0] idx_q;
	kind_e             kind_q;
	cnt_t              period_q;
	logic              zero_q;
	logic              rep_q;
	logic [5:0]        id_q;
	logic              id_bad_q;
	logic              pend_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [REP_W-1:0]  nrep_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [5:0]        slot_q;
	logic              fired_q;
	logic              last_q;

	resp_t             r;
	logic [$bits(resp_t)-1:0] r_bits;
	logic              accept, out_free, last_cell, running, fire, report;
	logic              emit, e_fired, e_last, pend_set, pend_clr, idx_step;
	stat_e             e_status;
	logic [5:0]        e_slot;

	always_comb begin
		r_bits = '0;
		for (int i = 0; i < SLOTS; i++) begin
			r_bits = r_bits | resp[i];
		end
		r = resp_t'(r_bits);
	end

	assign in_ready  = (fsm_q == F_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign last_cell = (idx_q == SLOT_W'(SLOTS - 1));
	assign running   = r.in_use && (r.run_state == RS_RUNNING);
	assign fire      = running && (r.ticks == COUNT_BITS'(1));
	assign report    = fire && (nrep_q < REP_W'(MAX_RESULTS));

	always_comb begin
		fsm_d       = fsm_q;
		ctl.start   = 1'b0;
		ctl.shift   = 1'b0;
		ctl.clear   = 1'b0;
		ctl.act     = ACT_NONE;
		ctl.period  = period_q;
		ctl.repeats = rep_q;
		emit        = 1'b0;
		e_status    = ST_OK;
		e_slot      = 6'(idx_q);
		e_fired     = 1'b0;
		e_last      = 1'b1;
		pend_set    = 1'b0;
		pend_clr    = 1'b0;
		idx_step    = 1'b0;

		unique case (fsm_q)
			F_IDLE: begin
				if (accept) begin
					ctl.start = 1'b1;
					ctl.shift = 1'b1;
					fsm_d     = F_SCAN;
				end
			end
			F_SCAN: begin
				unique case (kind_q)
					K_TICK: begin
						if (!(report && pend_q && !out_free)) begin
							if (running) begin
								ctl.act = ACT_TICK;
							end
							if (report) begin
								pend_set = 1'b1;
								if (pend_q) begin
									emit    = 1'b1;
									e_slot  = 6'(pend_slot_q);
									e_fired = 1'b1;
									e_last  = 1'b0;
								end
							end
							if (last_cell) begin
								ctl.clear = 1'b1;
								fsm_d     = F_FLUSH;
							end else begin
								ctl.shift = 1'b1;
								idx_step  = 1'b1;
							end
						end
					end
					K_ADD: begin
						if (zero_q) begin
							e_status = ST_INVALID;
							e_slot   = 6'd0;
							emit     = out_free;
						end else if (!r.in_use) begin
							emit = out_free;
							if (out_free) begin
								ctl.act = ACT_CLAIM;
							end
						end else if (last_cell) begin
							e_status = ST_NOSPACE;
							e_slot   = 6'd0;
							emit     = out_free;
						end else begin
							ctl.shift = 1'b1;
							idx_step  = 1'b1;
						end
						if (emit) begin
							ctl.clear = 1'b1;
							fsm_d     = F_IDLE;
						end
					end
					default: begin
						e_slot = id_q;
						if (id_bad_q) begin
							e_status = ST_INVALID;
							emit     = out_free;
						end else if (6'(idx_q) == id_q) begin
							emit = out_free;
							if (!r.in_use) begin
								e_status = ST_INVALID;
							end else if (kind_q == K_CANCEL) begin
								priority if (r.run_state == RS_CANCELLED) begin
									e_status = ST_CANCELLED;
								end else if (r.run_state == RS_FINISHED) begin
									e_status = ST_FINISHED;
								end else begin
									ctl.act = out_free ? ACT_CANCEL : ACT_NONE;
								end
							end else begin
								if (r.repeats || r.run_state == RS_RUNNING) begin
									e_status = ST_BUSY;
								end else begin
									ctl.act = out_free ? ACT_FREE : ACT_NONE;
								end
							end
						end else begin
							ctl.shift = 1'b1;
							idx_step  = 1'b1;
						end
						if (emit) begin
							ctl.clear = 1'b1;
							fsm_d     = F_IDLE;
						end
					end
				endcase
			end
			F_FLUSH: begin
				if (!pend_q) begin
					fsm_d = F_IDLE;
				end else if (out_free) begin
					emit     = 1'b1;
					e_slot   = 6'(pend_slot_q);
					e_fired  = 1'b1;
					pend_clr = 1'b1;
					fsm_d    = F_IDLE;
				end
			end
			default: begin
				fsm_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= F_IDLE;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			nrep_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q <= fsm_d;
			if (accept) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
				nrep_q <= '0;
			end else begin
				if (idx_step) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
				if (pend_set) begin
					pend_q <= 1'b1;
					nrep_q <= nrep_q + REP_W'(1);
				end else if (pend_clr) begin
					pend_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind_e'(kind);
			period_q <= sat_period(period_ticks);
			zero_q   <= (period_ticks == 16'd0);
			rep_q    <= periodic;
			id_q     <= slot_id;
			id_bad_q <= ({1'b0, slot_id} >= 7'(SLOTS));
		end
		if (pend_set) begin
			pend_slot_q <= idx_q;
		end
		if (emit) begin
			status_q <= e_status;
			slot_q   <= e_slot;
			fired_q  <= e_fired;
			last_q   <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign slot      = slot_q;
	assign fired     = fired_q;
	assign last      = last_q;

endmodule

@@ rtl/core/multi_slot_countdown_timer.sv @@
// ----------------------------------------------------------------------------
// multi_slot_countdown_timer
// Table of one-shot and periodic countdown slots with tick, add, cancel and
// release commands.
// ----------------------------------------------------------------------------
// One command word is taken at a time. A scan token walks the row of slot
// cells one cell per cycle and the sequencer acts on the cell that holds it,
// so the cost is set by that walk, plus any output stall: a tick walks every
// slot and returns one word per expired slot (last marks the final one,
// nothing if none expired); an add stops at the lowest free slot, or at
// once for a zero period; cancel and release stop at slot_id, or at once
// for a slot_id outside the table. All other replies are a single word with
// last set.
module multi_slot_countdown_timer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] period_ticks,
	input  logic        periodic,
	input  logic [5:0]  slot_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [5:0]  slot,
	output logic        fired,
	output logic        last
);
	import msct_pkg::*;

	ctl_t  ctl;
	resp_t resp [SLOTS];
	logic  tok_in  [SLOTS];
	logic  tok_out [SLOTS];

	msct_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.period_ticks (period_ticks),
		.periodic     (periodic),
		.slot_id      (slot_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot         (slot),
		.fired        (fired),
		.last         (last),
		.resp         (resp),
		.ctl          (ctl)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign tok_in[i] = ctl.start;
		end else begin : g_link
			assign tok_in[i] = tok_out[i-1];
		end

		msct_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (tok_in[i]),
			.ctl    (ctl),
			.tok_o  (tok_out[i]),
			.resp   (resp[i])
		);
	end

endmodule
